@@ rtl/line_sensor_centroid_tracker_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Line sensor centroid tracker - assertion macros
// Shared concurrent assertion forms used by the tracker modules.
// ---------------------------------------------------------------------------
`ifndef LINE_SENSOR_CENTROID_TRACKER_UNIT_MACROS_SVH
`define LINE_SENSOR_CENTROID_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LSCT_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define LSCT_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/lsct_pkg.sv @@
// ---------------------------------------------------------------------------
// Line sensor centroid tracker - package
// Widths, constants, register indexes and lane control type.
// ---------------------------------------------------------------------------
package lsct_pkg;

   // Rounds summed per frame
   localparam int OVERSAMPLE = 8;
   localparam int NUM_CH     = 8;

   localparam int SAMPLE_W   = 12;
   localparam int CH_W       = 3;
   localparam int SUM_W      = $clog2((1 << SAMPLE_W) * OVERSAMPLE);
   localparam int RND_W      = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
   localparam int SPACING_W  = 6;
   localparam int SMOOTH_W   = 8;
   localparam int STEP_W     = 13;
   localparam int WEIGHT_W   = 16;
   localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
   localparam int TOTAL_W    = 15;
   localparam int WSUM_W     = PROD_W + CH_W;
   localparam int POS_W      = 16;
   localparam int CNT_W      = 5;
   localparam int DIV_SHORT_SHIFT = WSUM_W - POS_W;
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;

   localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX    = 12'd4095;
   localparam logic [SAMPLE_W-1:0]  THRESHOLD_RST = 12'd2048;
   localparam logic [SPACING_W-1:0] SPACING_RST   = 6'd12;
   localparam logic [SMOOTH_W-1:0]  SMOOTH_RST    = 8'd4;
   localparam logic [POS_W-1:0]     POS_RST       = 16'd4200;
   localparam logic [TOTAL_W-1:0]   LOST_LIMIT    = 15'd50;
   localparam logic [STEP_W-1:0]    STEP_SCALE    = 13'd100;
   localparam logic [POS_W-1:0]     MAX_CH_IDX    = 16'd7;

   // Register indexes (byte address bits 3:2)
   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_SPACING   = 2'd1;
   localparam logic [1:0] REG_SMOOTH    = 2'd2;

   // Per-lane control strobes from the sequencer
   typedef struct packed {
      logic accept;
      logic frame_end;
      logic calc;
      logic mult;
   } lane_ctrl_type;

endpackage

@@ rtl/lsct_lane.sv @@
// ---------------------------------------------------------------------------
// Line sensor centroid tracker - channel lane
// Sums one channel over a frame, tracks its baseline, thresholds the
// average and forms the weighted darkness product for the centroid.
// ---------------------------------------------------------------------------
`include "line_sensor_centroid_tracker_unit_macros.svh"

module lsct_lane import lsct_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  lane_ctrl_type       ctrl,
   input  logic [CH_W-1:0]     lane_idx,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [SAMPLE_W-1:0] threshold,
   input  logic [STEP_W-1:0]   step,
   output logic [SAMPLE_W-1:0] dark,
   output logic [PROD_W-1:0]   prod,
   output logic                line_bit
);

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] baseline_ff, baseline_in;
   logic [SAMPLE_W-1:0] avg_ff;
   logic [SAMPLE_W-1:0] dark_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                bit_ff;

   // Running sum including the current sample, new baseline candidate
   assign sum_in      = sum_ff + SUM_W'(sample);
   assign baseline_in = (avg_ff < baseline_ff) ? avg_ff : baseline_ff;

   // Accumulate rounds, clear at frame end, lower the baseline
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         baseline_ff <= SAMPLE_MAX;
      end else begin
         if (ctrl.accept) begin
            sum_ff <= ctrl.frame_end ? '0 : sum_in;
         end
         if (ctrl.calc) begin
            baseline_ff <= baseline_in;
         end
      end
   end

   // Average, threshold, darkness and weighted product
   always_ff @(posedge clock) begin
      if (ctrl.accept && ctrl.frame_end) begin
         avg_ff <= SAMPLE_W'(sum_in / OVERSAMPLE);
      end
      if (ctrl.calc) begin
         bit_ff    <= (avg_ff > threshold);
         dark_ff   <= avg_ff - baseline_in;
         weight_ff <= WEIGHT_W'(lane_idx) * WEIGHT_W'(step);
      end
      if (ctrl.mult) begin
         prod_ff <= PROD_W'(dark_ff) * PROD_W'(weight_ff);
      end
   end

   assign dark     = dark_ff;
   assign prod     = prod_ff;
   assign line_bit = bit_ff;

   // Baseline only ever moves down
   `LSCT_ASSERT_NXT(a_baseline_falls, clock, reset, ctrl.calc, baseline_ff <= $past(baseline_ff), "baseline rose")

endmodule

@@ rtl/lsct_merge.sv @@
// ---------------------------------------------------------------------------
// Line sensor centroid tracker - lane merge
// Two-level registered adder tree over the lane darkness values and
// weighted products.
// ---------------------------------------------------------------------------
module lsct_merge import lsct_pkg::*; (
   input  logic                clock,
   input  logic [SAMPLE_W-1:0] dark [NUM_CH],
   input  logic [PROD_W-1:0]   prod [NUM_CH],
   output logic [TOTAL_W-1:0]  total,
   output logic [WSUM_W-1:0]   weighted
);

   localparam int PAIRS = NUM_CH / 2;

   logic [TOTAL_W-1:0] pair_total_ff [PAIRS];
   logic [WSUM_W-1:0]  pair_wsum_ff  [PAIRS];
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [WSUM_W-1:0]  weighted_ff, weighted_in;

   // First level: add neighboring lanes
   always_ff @(posedge clock) begin
      for (int i = 0; i < PAIRS; i++) begin
         pair_total_ff[i] <= TOTAL_W'(dark[2*i]) + TOTAL_W'(dark[2*i+1]);
         pair_wsum_ff[i]  <= WSUM_W'(prod[2*i]) + WSUM_W'(prod[2*i+1]);
      end
   end

   // Second level: fold the pair sums
   always_comb begin
      total_in    = '0;
      weighted_in = '0;
      for (int i = 0; i < PAIRS; i++) begin
         total_in    = total_in + pair_total_ff[i];
         weighted_in = weighted_in + pair_wsum_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      total_ff    <= total_in;
      weighted_ff <= weighted_in;
   end

   assign total    = total_ff;
   assign weighted = weighted_ff;

endmodule

@@ rtl/lsct_div.sv @@
// ---------------------------------------------------------------------------
// Line sensor centroid tracker - serial divider
// Restoring divider, one quotient bit per cycle. Long mode divides the
// full weighted sum; short mode divides a 16-bit value.
// ---------------------------------------------------------------------------
`include "line_sensor_centroid_tracker_unit_macros.svh"

module lsct_div import lsct_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               short_mode,
   input  logic [WSUM_W-1:0]  dividend,
   input  logic [TOTAL_W-1:0] divisor,
   output logic               done,
   output logic [WSUM_W-1:0]  quotient
);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [WSUM_W-1:0]  shift_ff;
   logic [WSUM_W-1:0]  quo_ff;
   logic [TOTAL_W-1:0] rem_ff, rem_in;
   logic [TOTAL_W-1:0] divisor_ff;
   logic [TOTAL_W:0]   trial;
   logic               fits;

   // Trial subtraction for the next quotient bit
   assign trial  = {rem_ff, shift_ff[WSUM_W-1]};
   assign fits   = (trial >= {1'b0, divisor_ff});
   assign rem_in = fits ? TOTAL_W'(trial - {1'b0, divisor_ff}) : trial[TOTAL_W-1:0];

   // Sequence the iterations
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= short_mode ? CNT_W'(POS_W) : CNT_W'(WSUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Load operands, then shift one bit per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff   <= short_mode ? {dividend[POS_W-1:0], {DIV_SHORT_SHIFT{1'b0}}}
                                  : dividend;
         divisor_ff <= divisor;
         rem_ff     <= '0;
         quo_ff     <= '0;
      end else if (busy_ff) begin
         shift_ff <= {shift_ff[WSUM_W-2:0], 1'b0};
         rem_ff   <= rem_in;
         quo_ff   <= {quo_ff[WSUM_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `LSCT_ASSERT_IMP(a_start_idle, clock, reset, start, !busy_ff, "divider started while busy")
   `LSCT_ASSERT_NXT(a_last_step_done, clock, reset, busy_ff && (cnt_ff == CNT_W'(1)) && !start, done_ff && !busy_ff, "divider missed its finish")

endmodule

@@ rtl/line_sensor_centroid_tracker_unit.sv @@
// ---------------------------------------------------------------------------
// Line sensor centroid tracker - top level
// Eight channel lanes sum a frame of samples; a merge tree and a serial
// divider form the clamped, smoothed line centroid once per frame.
// ---------------------------------------------------------------------------
//   Channel   Ports    Payload                                   Role
//   request   req_*    eight 12-bit samples, ch0 lowest          stream slave
//   response  rsp_*    line_bits, line_position; tuser line_lost stream master
//   config    csr_*    threshold, spacing, smoothing divisor     APB-style slave
//
// One item per cycle for all but the last round of a frame, which starts a
// frame pass: 5 lane and merge stages, the centroid division, two smoothing
// divides and a finish state (no smoothing divides with smoothing at zero, no
// division with the line lost). Reset is synchronous and active high. A waiting
// result sits in the output register while the next frame's items are taken;
// a stalled result only holds the block at the end of the following frame.
// ---------------------------------------------------------------------------
`include "line_sensor_centroid_tracker_unit_macros.svh"

module line_sensor_centroid_tracker_unit import lsct_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request stream
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [95:0]       req_tdata,   // sample_ch0 .. sample_ch7, 12 bits each
   // response stream
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // line_bits[7:0], line_position[23:8]
   output logic              rsp_tuser,   // line_lost
   // configuration port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_BASE   = 4'd1;
   localparam logic [3:0] ST_MULT   = 4'd2;
   localparam logic [3:0] ST_SUM1   = 4'd3;
   localparam logic [3:0] ST_SUM2   = 4'd4;
   localparam logic [3:0] ST_CHECK  = 4'd5;
   localparam logic [3:0] ST_DRAW   = 4'd6;
   localparam logic [3:0] ST_DPOS   = 4'd7;
   localparam logic [3:0] ST_DNEW   = 4'd8;
   localparam logic [3:0] ST_FINISH = 4'd9;

   logic [3:0]           state_ff, state_in;
   logic [RND_W-1:0]     round_ff;
   logic                 position_valid_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [POS_W-1:0]     raw_ff;
   logic [POS_W-1:0]     posq_ff;
   logic                 lost_ff;
   logic                 rsp_tvalid_ff;
   logic [NUM_CH-1:0]    rsp_bits_ff;
   logic [POS_W-1:0]     rsp_pos_ff;
   logic                 rsp_lost_ff;
   logic [SAMPLE_W-1:0]  threshold_ff;
   logic [SPACING_W-1:0] spacing_ff;
   logic [SMOOTH_W-1:0]  smooth_ff;

   logic                 req_accept;
   logic                 frame_end;
   logic                 out_free;
   logic                 csr_write;
   logic [STEP_W-1:0]    step;
   logic [POS_W-1:0]     max_pos;
   logic [POS_W-1:0]     raw_clamp;
   logic [POS_W:0]       ema_sum;
   lane_ctrl_type        lane_ctrl;

   logic [SAMPLE_W-1:0]  lane_dark [NUM_CH];
   logic [PROD_W-1:0]    lane_prod [NUM_CH];
   logic [NUM_CH-1:0]    lane_bits;
   logic [TOTAL_W-1:0]   total;
   logic [WSUM_W-1:0]    weighted;

   logic                 div_start;
   logic                 div_short;
   logic [WSUM_W-1:0]    div_dividend;
   logic [TOTAL_W-1:0]   div_divisor;
   logic                 div_done;
   logic [WSUM_W-1:0]    div_quot;

   // Handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign frame_end  = req_accept && (round_ff == RND_W'(OVERSAMPLE - 1));
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Position step and full scale at the current spacing
   assign step      = STEP_W'(spacing_ff) * STEP_SCALE;
   assign max_pos   = POS_W'(step) * MAX_CH_IDX;
   assign raw_clamp = (div_quot > WSUM_W'(max_pos)) ? max_pos : div_quot[POS_W-1:0];
   assign ema_sum   = {1'b0, pos_ff} - {1'b0, posq_ff} + {1'b0, div_quot[POS_W-1:0]};

   // Lane strobes
   assign lane_ctrl.accept    = req_accept;
   assign lane_ctrl.frame_end = frame_end;
   assign lane_ctrl.calc      = (state_ff == ST_BASE);
   assign lane_ctrl.mult      = (state_ff == ST_MULT);

   // Channel lanes
   for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
      lsct_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .lane_idx  (CH_W'(k)),
         .sample    (req_tdata[k*SAMPLE_W +: SAMPLE_W]),
         .threshold (threshold_ff),
         .step      (step),
         .dark      (lane_dark[k]),
         .prod      (lane_prod[k]),
         .line_bit  (lane_bits[k])
      );
   end

   lsct_merge u_merge (
      .clock    (clock),
      .dark     (lane_dark),
      .prod     (lane_prod),
      .total    (total),
      .weighted (weighted)
   );

   lsct_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .short_mode (div_short),
      .dividend   (div_dividend),
      .divisor    (div_divisor),
      .done       (div_done),
      .quotient   (div_quot)
   );

   // Frame sequencer and divider requests
   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_short    = 1'b0;
      div_dividend = weighted;
      div_divisor  = total;
      case (state_ff)
         ST_IDLE: begin
            if (frame_end) state_in = ST_BASE;
         end
         ST_BASE:  state_in = ST_MULT;
         ST_MULT:  state_in = ST_SUM1;
         ST_SUM1:  state_in = ST_SUM2;
         ST_SUM2:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (total < LOST_LIMIT) begin
               state_in = ST_FINISH;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (div_done) begin
               if (smooth_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  div_start    = 1'b1;
                  div_short    = 1'b1;
                  div_dividend = WSUM_W'(pos_ff);
                  div_divisor  = TOTAL_W'(smooth_ff);
                  state_in     = ST_DPOS;
               end
            end
         end
         ST_DPOS: begin
            if (div_done) begin
               div_start    = 1'b1;
               div_short    = 1'b1;
               div_dividend = WSUM_W'(raw_ff);
               div_divisor  = TOTAL_W'(smooth_ff);
               state_in     = ST_DNEW;
            end
         end
         ST_DNEW: begin
            if (div_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state, position, output valid and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         round_ff          <= '0;
         position_valid_ff <= 1'b0;
         pos_ff            <= POS_RST;
         rsp_tvalid_ff     <= 1'b0;
         threshold_ff      <= THRESHOLD_RST;
         spacing_ff        <= SPACING_RST;
         smooth_ff         <= SMOOTH_RST;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            round_ff <= frame_end ? '0 : round_ff + 1'b1;
         end
         // Load the center on the first frame
         if (state_ff == ST_CHECK && !position_valid_ff) begin
            pos_ff            <= max_pos >> 1;
            position_valid_ff <= 1'b1;
         end
         if (state_ff == ST_DRAW && div_done && smooth_ff == '0) begin
            pos_ff <= raw_clamp;
         end
         if (state_ff == ST_DNEW && div_done) begin
            pos_ff <= ema_sum[POS_W-1:0];
         end
         // Hold the result until taken
         if (state_ff == ST_FINISH && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (csr_write) begin
            case (csr_paddr[3:2])
               REG_THRESHOLD: threshold_ff <= csr_pwdata[SAMPLE_W-1:0];
               REG_SPACING:   spacing_ff   <= csr_pwdata[SPACING_W-1:0];
               REG_SMOOTH:    smooth_ff    <= csr_pwdata[SMOOTH_W-1:0];
               default:       ;
            endcase
         end
      end
   end

   // Intermediate quotients and result payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) begin
         lost_ff <= (total < LOST_LIMIT);
      end
      if (state_ff == ST_DRAW && div_done) begin
         raw_ff <= raw_clamp;
      end
      if (state_ff == ST_DPOS && div_done) begin
         posq_ff <= div_quot[POS_W-1:0];
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_bits_ff <= lane_bits;
         rsp_pos_ff  <= pos_ff;
         rsp_lost_ff <= lost_ff;
      end
   end

   // Register readback
   always_comb begin
      case (csr_paddr[3:2])
         REG_THRESHOLD: csr_prdata = DATA_W'(threshold_ff);
         REG_SPACING:   csr_prdata = DATA_W'(spacing_ff);
         REG_SMOOTH:    csr_prdata = DATA_W'(smooth_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_pos_ff, rsp_bits_ff};
   assign rsp_tuser  = rsp_lost_ff;

   `LSCT_ASSERT_IMP(a_div_done_waited, clock, reset, div_done, (state_ff == ST_DRAW) || (state_ff == ST_DPOS) || (state_ff == ST_DNEW), "divider finished with nobody waiting")
   `LSCT_ASSERT_IMP(a_finish_has_pos, clock, reset, state_ff == ST_FINISH, position_valid_ff, "result without a loaded position")

endmodule
